### rtl/bpf_pkg.sv
// Shared types, widths and rule constants of the box plausibility filter.
// No dependencies; used by every module of the block.
package bpf_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = 17;
    localparam int SQ_W    = 33;
    localparam int SIDE_W  = 17;
    localparam int HGT_W   = 18;
    localparam int HP_W    = 24;
    localparam int CNT_W   = 16;
    localparam int AREA_W  = 34;
    localparam int VOL_W   = 58;

    localparam logic [15:0] MIN_POINTS    = 16'd30;
    localparam logic [16:0] LENGTH_MIN    = 17'd51;
    localparam logic [16:0] LONG_SIDE_MIN = 17'd768;
    localparam logic [23:0] RATIO_MIN     = 24'd1;
    localparam logic [23:0] RATIO_MAX     = 24'd8;

    typedef enum logic [2:0] {
        REG_SENSOR_HEIGHT = 3'd0,
        REG_HEIGHT_MIN    = 3'd1,
        REG_HEIGHT_MAX    = 3'd2,
        REG_WIDTH_MIN     = 3'd3,
        REG_WIDTH_MAX     = 3'd4,
        REG_LENGTH_MAX    = 3'd5,
        REG_AREA_MAX      = 3'd6,
        REG_DENSITY       = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [14:0] sensor_height;
        logic [15:0] height_min;
        logic [15:0] height_max;
        logic [15:0] width_min;
        logic [15:0] width_max;
        logic [16:0] length_max;
        logic [21:0] area_max;
        logic [7:0]  points_per_cubic_m;
    } t_cfg;

    // Per-item values that ride alongside the square roots.
    typedef struct packed {
        logic signed [HGT_W-1:0] height;
        logic [HP_W-1:0]         hp;
        logic [CNT_W-1:0]        count;
    } t_side;

endpackage

### rtl/bpf_regs.sv
// APB-style configuration register file of the box plausibility filter.
// Depends on bpf_pkg for the register index codes and the t_cfg struct.
module bpf_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output bpf_pkg::t_cfg     o_cfg
);

    bpf_pkg::t_cfg r_cfg;
    bpf_pkg::t_reg_idx idx;

    assign idx    = bpf_pkg::t_reg_idx'(paddr[4:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensor_height      <= 15'd512;
            r_cfg.height_min         <= 16'd205;
            r_cfg.height_max         <= 16'd666;
            r_cfg.width_min          <= 16'd51;
            r_cfg.width_max          <= 16'd896;
            r_cfg.length_max         <= 17'd3584;
            r_cfg.area_max           <= 22'd5120;
            r_cfg.points_per_cubic_m <= 8'd8;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                bpf_pkg::REG_SENSOR_HEIGHT: r_cfg.sensor_height      <= pwdata[14:0];
                bpf_pkg::REG_HEIGHT_MIN:    r_cfg.height_min         <= pwdata[15:0];
                bpf_pkg::REG_HEIGHT_MAX:    r_cfg.height_max         <= pwdata[15:0];
                bpf_pkg::REG_WIDTH_MIN:     r_cfg.width_min          <= pwdata[15:0];
                bpf_pkg::REG_WIDTH_MAX:     r_cfg.width_max          <= pwdata[15:0];
                bpf_pkg::REG_LENGTH_MAX:    r_cfg.length_max         <= pwdata[16:0];
                bpf_pkg::REG_AREA_MAX:      r_cfg.area_max           <= pwdata[21:0];
                bpf_pkg::REG_DENSITY:       r_cfg.points_per_cubic_m <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            bpf_pkg::REG_SENSOR_HEIGHT: prdata = {17'd0, r_cfg.sensor_height};
            bpf_pkg::REG_HEIGHT_MIN:    prdata = {16'd0, r_cfg.height_min};
            bpf_pkg::REG_HEIGHT_MAX:    prdata = {16'd0, r_cfg.height_max};
            bpf_pkg::REG_WIDTH_MIN:     prdata = {16'd0, r_cfg.width_min};
            bpf_pkg::REG_WIDTH_MAX:     prdata = {16'd0, r_cfg.width_max};
            bpf_pkg::REG_LENGTH_MAX:    prdata = {15'd0, r_cfg.length_max};
            bpf_pkg::REG_AREA_MAX:      prdata = {10'd0, r_cfg.area_max};
            bpf_pkg::REG_DENSITY:       prdata = {24'd0, r_cfg.points_per_cubic_m};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

### rtl/bpf_sqrt_pipe.sv
// Two-lane pipelined integer square root, one result bit per register stage.
// Depends on bpf_pkg for widths and the t_side struct carried with each item.
module bpf_sqrt_pipe (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic [bpf_pkg::SQ_W-1:0]     i_sq_a,
    input  logic [bpf_pkg::SQ_W-1:0]     i_sq_b,
    input  bpf_pkg::t_side               i_side,
    output logic                         o_vld,
    output logic [bpf_pkg::SIDE_W-1:0]   o_root_a,
    output logic [bpf_pkg::SIDE_W-1:0]   o_root_b,
    output bpf_pkg::t_side               o_side
);

    localparam int STAGES = bpf_pkg::SIDE_W;
    localparam int RES_W  = bpf_pkg::SQ_W + 1;

    logic [bpf_pkg::SQ_W-1:0] rem_a [0:STAGES];
    logic [bpf_pkg::SQ_W-1:0] rem_b [0:STAGES];
    logic [RES_W-1:0]         res_a [0:STAGES];
    logic [RES_W-1:0]         res_b [0:STAGES];
    bpf_pkg::t_side           side  [0:STAGES];
    logic                     vld   [0:STAGES];

    assign rem_a[0] = i_sq_a;
    assign rem_b[0] = i_sq_b;
    assign res_a[0] = '0;
    assign res_b[0] = '0;
    assign side[0]  = i_side;
    assign vld[0]   = i_vld;

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam int BIT_POS = 2 * (STAGES - 1 - k);
        localparam logic [RES_W-1:0] BIT = RES_W'(1) << BIT_POS;

        logic [RES_W-1:0]         trial_a, trial_b;
        logic [bpf_pkg::SQ_W-1:0] n_rem_a, n_rem_b;
        logic [RES_W-1:0]         n_res_a, n_res_b;
        logic [bpf_pkg::SQ_W-1:0] r_rem_a, r_rem_b;
        logic [RES_W-1:0]         r_res_a, r_res_b;
        bpf_pkg::t_side           r_side;
        logic                     r_vld;

        always_comb begin
            trial_a = res_a[k] + BIT;
            trial_b = res_b[k] + BIT;
            if ({1'b0, rem_a[k]} >= trial_a) begin
                n_rem_a = rem_a[k] - trial_a[bpf_pkg::SQ_W-1:0];
                n_res_a = (res_a[k] >> 1) + BIT;
            end else begin
                n_rem_a = rem_a[k];
                n_res_a = res_a[k] >> 1;
            end
            if ({1'b0, rem_b[k]} >= trial_b) begin
                n_rem_b = rem_b[k] - trial_b[bpf_pkg::SQ_W-1:0];
                n_res_b = (res_b[k] >> 1) + BIT;
            end else begin
                n_rem_b = rem_b[k];
                n_res_b = res_b[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= vld[k];
            end
            if (i_en) begin
                r_rem_a <= n_rem_a;
                r_rem_b <= n_rem_b;
                r_res_a <= n_res_a;
                r_res_b <= n_res_b;
                r_side  <= side[k];
            end
        end

        assign rem_a[k+1] = r_rem_a;
        assign rem_b[k+1] = r_rem_b;
        assign res_a[k+1] = r_res_a;
        assign res_b[k+1] = r_res_b;
        assign side[k+1]  = r_side;
        assign vld[k+1]   = r_vld;
    end

    assign o_vld    = vld[STAGES];
    assign o_root_a = res_a[STAGES][bpf_pkg::SIDE_W-1:0];
    assign o_root_b = res_b[STAGES][bpf_pkg::SIDE_W-1:0];
    assign o_side   = side[STAGES];

endmodule

### rtl/box_plausibility_filter.sv
// Top level of the box plausibility filter: input differences and squares,
// square-root pipeline, rule checks and output register. Uses bpf_pkg,
// bpf_regs and bpf_sqrt_pipe.
//
// Usage: each input item is one fitted box (corners A, B, C, top_z and the
// point count), offered on i_valid/o_ready. Each item yields exactly one
// result item on o_valid/i_ready: the accept flag and the long and short
// side lengths in 1/256 m.
// From acceptance to o_valid each item passes the input stages for the
// differences, squares and sums, the seventeen-stage square-root pipeline
// with one bit per stage, and the post stages for the area, volume products
// and rule checks. Throughput is one item per cycle while no result waits
// on a low i_ready; the root stages and split multiplier set the depth only.
// When the receiver holds i_ready low while a result waits, the whole
// pipeline freezes in place and o_ready falls; while no result waits, the
// pipeline keeps moving whatever i_ready does, so a stall loses and repeats
// nothing. A synchronous active-low reset clears all valid bits and loads
// the configuration registers with their defaults.
// Configuration goes through the APB-style port and should only change
// while no item is in flight.
module box_plausibility_filter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [15:0]   i_corner_a_x,
    input  logic signed [15:0]   i_corner_a_y,
    input  logic signed [15:0]   i_corner_b_x,
    input  logic signed [15:0]   i_corner_b_y,
    input  logic signed [15:0]   i_corner_c_x,
    input  logic signed [15:0]   i_corner_c_y,
    input  logic signed [15:0]   i_top_z,
    input  logic [15:0]          i_point_count,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_accept,
    output logic [16:0]          o_long_side,
    output logic [16:0]          o_short_side,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int DW = bpf_pkg::DIFF_W;
    localparam int SW = bpf_pkg::SIDE_W;

    bpf_pkg::t_cfg cfg;
    logic          en;

    bpf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The pipeline advances as a whole unless a finished result is waiting.
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // Stage 1: coordinate differences and the absolute height.
    logic signed [DW-1:0] r1_dxa, r1_dya, r1_dxc, r1_dyc;
    bpf_pkg::t_side       r1_side;
    logic                 r1_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_valid;
        end
        if (en) begin
            r1_dxa         <= DW'(i_corner_a_x) - DW'(i_corner_b_x);
            r1_dya         <= DW'(i_corner_a_y) - DW'(i_corner_b_y);
            r1_dxc         <= DW'(i_corner_c_x) - DW'(i_corner_b_x);
            r1_dyc         <= DW'(i_corner_c_y) - DW'(i_corner_b_y);
            r1_side.height <= bpf_pkg::HGT_W'(i_top_z)
                            + $signed({3'b000, cfg.sensor_height});
            r1_side.hp     <= '0;
            r1_side.count  <= i_point_count;
        end
    end

    // Stage 2: squared differences; height times density for the volume.
    logic [31:0]     r2_sxa, r2_sya, r2_sxc, r2_syc;
    logic [2*DW-1:0] p_xa, p_ya, p_xc, p_yc;
    bpf_pkg::t_side  r2_side;
    logic            r2_vld;

    assign p_xa = r1_dxa * r1_dxa;
    assign p_ya = r1_dya * r1_dya;
    assign p_xc = r1_dxc * r1_dxc;
    assign p_yc = r1_dyc * r1_dyc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
        if (en) begin
            r2_sxa         <= p_xa[31:0];
            r2_sya         <= p_ya[31:0];
            r2_sxc         <= p_xc[31:0];
            r2_syc         <= p_yc[31:0];
            r2_side.height <= r1_side.height;
            r2_side.count  <= r1_side.count;
            // Only meaningful for a positive height below 2^16, which the
            // height band guarantees whenever the volume test matters.
            r2_side.hp     <= r1_side.height[15:0] * bpf_pkg::HP_W'(cfg.points_per_cubic_m);
        end
    end

    // Stage 3: squared side lengths.
    logic [bpf_pkg::SQ_W-1:0] r3_sq_a, r3_sq_b;
    bpf_pkg::t_side           r3_side;
    logic                     r3_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
        if (en) begin
            r3_sq_a <= {1'b0, r2_sxa} + {1'b0, r2_sya};
            r3_sq_b <= {1'b0, r2_sxc} + {1'b0, r2_syc};
            r3_side <= r2_side;
        end
    end

    // Square roots, one result bit per stage.
    logic [SW-1:0]  d1, d2;
    bpf_pkg::t_side s_side;
    logic           s_vld;

    bpf_sqrt_pipe u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (r3_vld),
        .i_sq_a   (r3_sq_a),
        .i_sq_b   (r3_sq_b),
        .i_side   (r3_side),
        .o_vld    (s_vld),
        .o_root_a (d1),
        .o_root_b (d2),
        .o_side   (s_side)
    );

    // Post stage 1: order the sides, area and the first volume product.
    logic [SW-1:0]              p1_len, p1_wid, p1_d1;
    logic [bpf_pkg::AREA_W-1:0] p1_area;
    logic [SW+bpf_pkg::HP_W-1:0] p1_m;
    bpf_pkg::t_side             p1_side;
    logic                       p1_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            p1_vld <= 1'b0;
        end else if (en) begin
            p1_vld <= s_vld;
        end
        if (en) begin
            p1_len  <= (d1 > d2) ? d1 : d2;
            p1_wid  <= (d1 > d2) ? d2 : d1;
            p1_d1   <= d1;
            p1_area <= d1 * d2;
            p1_m    <= d2 * s_side.hp;
            p1_side <= s_side;
        end
    end

    // Post stage 2: band, area and ratio rules; volume cut in two products.
    logic                         band_ok, ratio_ok;
    logic [23:0]                  wid_lo, wid_hi;
    logic                         p2_ok;
    logic [SW+24-1:0]             p2_pp_lo;
    logic [2*SW-1:0]              p2_pp_hi;
    logic [SW-1:0]                p2_len, p2_wid;
    logic [bpf_pkg::CNT_W-1:0]    p2_count;
    logic                         p2_vld;

    assign wid_lo = 24'(p1_wid) * bpf_pkg::RATIO_MIN;
    assign wid_hi = 24'(p1_wid) * bpf_pkg::RATIO_MAX;

    always_comb begin
        band_ok = (p1_side.count >= bpf_pkg::MIN_POINTS)
               && (p1_side.height > $signed({2'b00, cfg.height_min}))
               && (p1_side.height < $signed({2'b00, cfg.height_max}))
               && (p1_wid > {1'b0, cfg.width_min})
               && (p1_wid < {1'b0, cfg.width_max})
               && (p1_len > bpf_pkg::LENGTH_MIN)
               && (p1_len < cfg.length_max)
               && (p1_area < {4'd0, cfg.area_max, 8'd0});
        // Long boxes must also keep their aspect ratio inside the band.
        ratio_ok = !(p1_len > bpf_pkg::LONG_SIDE_MIN)
                || ((24'(p1_len) > wid_lo) && (24'(p1_len) < wid_hi));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            p2_vld <= 1'b0;
        end else if (en) begin
            p2_vld <= p1_vld;
        end
        if (en) begin
            p2_ok    <= band_ok && ratio_ok;
            p2_pp_lo <= p1_d1 * p1_m[23:0];
            p2_pp_hi <= p1_d1 * p1_m[SW+23:24];
            p2_len   <= p1_len;
            p2_wid   <= p1_wid;
            p2_count <= p1_side.count;
        end
    end

    // Post stage 3: volume sum and density rule, into the output register.
    logic [bpf_pkg::VOL_W-1:0] vol;
    logic                      r_ovld;
    logic                      r_accept;
    logic [SW-1:0]             r_long, r_short;

    assign vol = bpf_pkg::VOL_W'(p2_pp_lo) + {p2_pp_hi, 24'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= p2_vld;
        end
        if (en) begin
            r_accept <= p2_ok && ({18'd0, p2_count, 24'd0} > vol);
            r_long   <= p2_len;
            r_short  <= p2_wid;
        end
    end

    assign o_valid      = r_ovld;
    assign o_accept     = r_accept;
    assign o_long_side  = r_long;
    assign o_short_side = r_short;

endmodule

### dv/box_plausibility_filter_tb.sv
// Self-checking testbench for the box plausibility filter: drives fitted boxes,
// predicts accept and side lengths, and compares every result item in order.
// Depends on bpf_pkg and the box_plausibility_filter top level.
module box_plausibility_filter_tb;

    // One box as offered on the input channel.
    typedef struct packed {
        logic signed [15:0] ax, ay, bx, by, cx, cy, tz;
        logic [15:0]        cnt;
    } t_box;

    // One verdict as produced on the result channel.
    typedef struct packed {
        logic        accept;
        logic [16:0] long_side;
        logic [16:0] short_side;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic signed [15:0] i_corner_a_x = '0, i_corner_a_y = '0, i_corner_b_x = '0;
    logic signed [15:0] i_corner_b_y = '0, i_corner_c_x = '0, i_corner_c_y = '0;
    logic signed [15:0] i_top_z = '0;
    logic [15:0] i_point_count = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_accept;
    logic [16:0] o_long_side, o_short_side;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    box_plausibility_filter dut (.*);

    always #4 i_clk = ~i_clk;

    // Shadow copy of the configuration registers, updated with every write.
    bpf_pkg::t_cfg shadow_cfg;

    t_box     pending_boxes[$];
    t_verdict expected_verdicts[$];
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       mismatches = 0;
    int       boxes_sent = 0;
    int       verdicts_seen = 0;
    int       accepts_seen = 0;

    // Appends one box to the tail of the pending queue.
    function automatic void add_box(input t_box b);
        pending_boxes.insert(pending_boxes.size(), b);
    endfunction

    // Bit-serial floor square root, independent of the block's pipeline.
    function automatic logic [16:0] floor_sqrt(input logic [33:0] v);
        logic [33:0] rem;
        logic [33:0] root;
        logic [33:0] bitv;
        rem = v;
        root = '0;
        bitv = 34'h1 << 32;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root[16:0];
    endfunction

    function automatic logic [16:0] side_len(input logic signed [15:0] x0, y0, x1, y1);
        logic signed [16:0] dx, dy;
        logic [33:0] sq;
        dx = 17'(x0) - 17'(x1);
        dy = 17'(y0) - 17'(y1);
        sq = 34'(unsigned'(34'(dx * dx))) + 34'(unsigned'(34'(dy * dy)));
        return floor_sqrt(sq);
    endfunction

    // Predicts the verdict of one box under the current shadow configuration.
    function automatic t_verdict judge_box(input t_box b);
        t_verdict v;
        logic [16:0] d1, d2, len, wid;
        logic [33:0] area;
        longint signed hgt;
        logic [127:0] vol;
        logic ok;
        d1 = side_len(b.ax, b.ay, b.bx, b.by);
        d2 = side_len(b.cx, b.cy, b.bx, b.by);
        len = (d1 > d2) ? d1 : d2;
        wid = (d1 > d2) ? d2 : d1;
        area = 34'(d1) * 34'(d2);
        hgt = longint'(b.tz) + longint'(shadow_cfg.sensor_height);
        ok = 1'b1;
        if (b.cnt < bpf_pkg::MIN_POINTS) ok = 1'b0;
        if (!(hgt > longint'(shadow_cfg.height_min) && hgt < longint'(shadow_cfg.height_max)))
            ok = 1'b0;
        if (!(wid > shadow_cfg.width_min && wid < shadow_cfg.width_max)) ok = 1'b0;
        if (!(len > bpf_pkg::LENGTH_MIN && len < shadow_cfg.length_max)) ok = 1'b0;
        if (!(64'(area) < 64'(shadow_cfg.area_max) * 256)) ok = 1'b0;
        if (ok) begin
            // Height is positive here, so the volume product is unsigned.
            vol = 128'(area) * 128'(hgt) * 128'(shadow_cfg.points_per_cubic_m);
            if (!((128'(b.cnt) << 24) > vol)) ok = 1'b0;
        end
        if (ok && len > bpf_pkg::LONG_SIDE_MIN) begin
            if (!(64'(len) > 64'(bpf_pkg::RATIO_MIN) * 64'(wid)
                  && 64'(len) < 64'(bpf_pkg::RATIO_MAX) * 64'(wid)))
                ok = 1'b0;
        end
        v.accept = ok;
        v.long_side = len;
        v.short_side = wid;
        return v;
    endfunction

    // Driver: presents the queue head and holds it until accepted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_verdicts.insert(expected_verdicts.size(),
                    judge_box({i_corner_a_x, i_corner_a_y,
                    i_corner_b_x, i_corner_b_y, i_corner_c_x, i_corner_c_y,
                    i_top_z, i_point_count}));
                boxes_sent <= boxes_sent + 1;
            end
            if (!i_valid || o_ready) begin
                if (pending_boxes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_box b;
                    b = pending_boxes.pop_front();
                    i_valid <= 1'b1;
                    {i_corner_a_x, i_corner_a_y, i_corner_b_x, i_corner_b_y,
                     i_corner_c_x, i_corner_c_y, i_top_z, i_point_count} <= b;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: checks each accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t: result with nothing expected: accept=%0b long=%0d short=%0d",
                         $time, o_accept, o_long_side, o_short_side);
                mismatches <= mismatches + 1;
            end else begin
                t_verdict e;
                e = expected_verdicts.pop_front();
                if (e.accept !== o_accept || e.long_side !== o_long_side ||
                    e.short_side !== o_short_side) begin
                    $display("%0t: mismatch expected accept=%0b long=%0d short=%0d,",
                             $time, e.accept, e.long_side, e.short_side,
                             " actual accept=%0b long=%0d short=%0d",
                             o_accept, o_long_side, o_short_side);
                    mismatches <= mismatches + 1;
                end
                verdicts_seen <= verdicts_seen + 1;
                accepts_seen <= accepts_seen + e.accept;
            end
        end
    end

    // APB write with setup and access phases; the shadow copy follows the register map.
    task automatic write_reg(input bpf_pkg::t_reg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 5'(idx) << 2; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            bpf_pkg::REG_SENSOR_HEIGHT: shadow_cfg.sensor_height = value[14:0];
            bpf_pkg::REG_HEIGHT_MIN:    shadow_cfg.height_min = value[15:0];
            bpf_pkg::REG_HEIGHT_MAX:    shadow_cfg.height_max = value[15:0];
            bpf_pkg::REG_WIDTH_MIN:     shadow_cfg.width_min = value[15:0];
            bpf_pkg::REG_WIDTH_MAX:     shadow_cfg.width_max = value[15:0];
            bpf_pkg::REG_LENGTH_MAX:    shadow_cfg.length_max = value[16:0];
            bpf_pkg::REG_AREA_MAX:      shadow_cfg.area_max = value[21:0];
            bpf_pkg::REG_DENSITY:       shadow_cfg.points_per_cubic_m = value[7:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input bpf_pkg::t_cfg c);
        write_reg(bpf_pkg::REG_SENSOR_HEIGHT, 32'(c.sensor_height));
        write_reg(bpf_pkg::REG_HEIGHT_MIN, 32'(c.height_min));
        write_reg(bpf_pkg::REG_HEIGHT_MAX, 32'(c.height_max));
        write_reg(bpf_pkg::REG_WIDTH_MIN, 32'(c.width_min));
        write_reg(bpf_pkg::REG_WIDTH_MAX, 32'(c.width_max));
        write_reg(bpf_pkg::REG_LENGTH_MAX, 32'(c.length_max));
        write_reg(bpf_pkg::REG_AREA_MAX, 32'(c.area_max));
        write_reg(bpf_pkg::REG_DENSITY, 32'(c.points_per_cubic_m));
    endtask

    // Waits until the queue is sent and every prediction has been matched.
    task automatic drain;
        while (pending_boxes.size() > 0 || i_valid || expected_verdicts.size() > 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // A plausible car-sized box around a random origin, with random jitter,
    // so that most random boxes reach the deeper rules.
    function automatic t_box plausible_box();
        t_box b;
        int ox, oy, l, w;
        ox = $urandom_range(20000) - 10000;
        oy = $urandom_range(20000) - 10000;
        l = $urandom_range(1100, 20);
        w = $urandom_range(500, 20);
        b.bx = 16'(ox); b.by = 16'(oy);
        if ($urandom_range(1)) begin
            b.ax = 16'(ox + l); b.ay = 16'(oy);
            b.cx = 16'(ox); b.cy = 16'(oy + w);
        end else begin
            b.ax = 16'(ox + l / 2); b.ay = 16'(oy + l);
            b.cx = 16'(ox - w); b.cy = 16'(oy + w / 3);
        end
        b.tz = 16'($urandom_range(500) - 350);
        b.cnt = 16'($urandom_range(2000));
        return b;
    endfunction

    function automatic t_box noise_box();
        t_box b;
        b = {$urandom, $urandom, $urandom, $urandom};
        return b;
    endfunction

    function automatic t_box mk(input int ax, ay, bx, by, cx, cy, tz, cnt);
        t_box b;
        b = {16'(ax), 16'(ay), 16'(bx), 16'(by), 16'(cx), 16'(cy), 16'(tz), 16'(cnt)};
        return b;
    endfunction

    task automatic random_phase(input int n);
        repeat (n) begin
            if ($urandom_range(99) < 80) add_box(plausible_box());
            else add_box(noise_box());
        end
        drain();
    endtask

    initial begin
        bpf_pkg::t_cfg c;
        shadow_cfg = '{sensor_height: 15'd512, height_min: 16'd205, height_max: 16'd666,
                       width_min: 16'd51, width_max: 16'd896, length_max: 17'd3584,
                       area_max: 22'd5120, points_per_cubic_m: 8'd8};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 34;
        recv_idle_pct = 64;

        // Directed boxes under the reset configuration.
        add_box(mk(300, 0, 0, 0, 0, 200, 0, 100));        // ordinary accept
        add_box(mk(300, 0, 0, 0, 0, 200, 0, 29));         // too few points
        add_box(mk(300, 0, 0, 0, 0, 200, 0, 30));         // minimum points
        add_box(mk(250, 0, 0, 0, 0, 250, 0, 200));        // equal sides
        add_box(mk(900, 0, 0, 0, 0, 0, 0, 500));          // zero width
        add_box(mk(1000, 0, 0, 0, 0, 100, 0, 9000));      // ratio too high
        add_box(mk(1000, 0, 0, 0, 0, 300, 0, 9000));      // long box in band
        add_box(mk(300, 0, 0, 0, 0, 200, -600, 100));     // negative height
        add_box(mk(300, 0, 0, 0, 0, 200, 100, 31));       // taller box with few points, still dense enough
        add_box(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, 65535));
        add_box(mk(32767, 32767, -32768, -32768, 32767, -32768, -32768, 0));
        add_box(mk(0, 0, 0, 0, 0, 0, 0, 0));
        add_box(mk(-1, -1, -1, -1, -1, -1, -1, 65535));
        add_box(mk(5, 5, 5, 5, 5, 5, 5, 5));
        drain();

        random_phase(130);
        send_idle_pct = 64;
        recv_idle_pct = 34;

        // Wide-open limits: most plausible boxes pass; extremes of every register.
        c = '{sensor_height: 15'h7fff, height_min: 16'd0, height_max: 16'hffff,
              width_min: 16'd0, width_max: 16'hffff, length_max: 17'h1ffff,
              area_max: 22'h3fffff, points_per_cubic_m: 8'd0};
        load_config(c);
        add_box(mk(300, 0, 0, 0, 0, 200, 0, 30));
        random_phase(130);

        // Zero limits with full density reject everything; then a mid setting with a density of one.
        c = '{sensor_height: 15'd0, height_min: 16'd0, height_max: 16'd0,
              width_min: 16'd0, width_max: 16'd0, length_max: 17'd0,
              area_max: 22'd0, points_per_cubic_m: 8'hff};
        load_config(c);
        random_phase(20);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        c = '{sensor_height: 15'd700, height_min: 16'd100, height_max: 16'd1500,
              width_min: 16'd10, width_max: 16'd700, length_max: 17'd2000,
              area_max: 22'd8000, points_per_cubic_m: 8'd1};
        load_config(c);
        random_phase(120);

        $display("Sent %0d boxes over four register settings;", boxes_sent,
                 " checked %0d verdicts, %0d accepted.", verdicts_seen, accepts_seen);
        if (mismatches == 0) begin
            $display("** box_plausibility_filter: PASSED **");
        end else begin
            $display("** box_plausibility_filter: FAILED **");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("** box_plausibility_filter: FAILED **");
        $finish;
    end
endmodule

### files.f
rtl/bpf_pkg.sv
rtl/bpf_regs.sv
rtl/bpf_sqrt_pipe.sv
rtl/box_plausibility_filter.sv
dv/box_plausibility_filter_tb.sv
